>>> rtl/ssi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ssi_pkg - segment/sphere intersection shared definitions
// Widths, stage records and the per-stage square root and divide steps.
// ============================================================================
package ssi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 33;            // coordinate difference
    localparam int SW        = 66;            // squares, sums, remainders
    localparam int LW        = 33;            // square root result
    localparam int QB        = 34;            // quotient bits of b
    localparam int QO        = 32;            // quotient bits of offsets
    localparam int BW        = QB + 1;        // signed b
    localparam int TW        = LW;            // t when inside the segment
    localparam int N_STAGES  = 3 + LW + QB + 2 + LW + 2 + QO + 1;

    localparam logic [LW-1:0] DEGEN_LSB =
        LW'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
    localparam logic [30:0] RADIUS_RESET = 31'(64'd1 << FRAC_BITS);

    typedef logic [2:0][31:0]    vec32_t;
    typedef logic [2:0][CW-1:0]  vecd_t;
    typedef logic [2:0][SW-1:0]  vecw_t;

    typedef struct packed {
        vec32_t s;
        vecd_t  d;
    } geom_t;

    typedef struct packed {
        geom_t g;
        vecd_t rel;
        logic  sealed;
    } a_t;

    typedef struct packed {
        geom_t       g;
        logic        sealed;
        vecw_t       dd;
        vecw_t       rd;
        vecw_t       rr;
        logic [61:0] rsq;
    } b_t;

    typedef struct packed {
        geom_t         g;
        logic          sealed;
        logic [SW-1:0] len2;
        logic [SW:0]   dot;
        logic [SW:0]   c;
    } c_t;

    typedef struct packed {
        geom_t         g;
        logic          sealed;
        logic [SW:0]   dot;
        logic [SW:0]   c;
        logic [SW-1:0] rad;
        logic [LW+1:0] rem;
        logic [LW-1:0] root;
    } l_t;

    typedef struct packed {
        geom_t         g;
        logic          miss;
        logic [SW:0]   c;
        logic [LW-1:0] len;
        logic          neg;
        logic [SW-1:0] rem;
        logic [QB-1:0] q;
    } d_t;

    typedef struct packed {
        geom_t           g;
        logic            miss;
        logic [SW:0]     c;
        logic [LW-1:0]   len;
        logic [BW-1:0]   b;
        logic [2*QB-1:0] bb;
    } e_t;

    typedef struct packed {
        geom_t         g;
        logic          miss;
        logic [LW-1:0] len;
        logic [BW-1:0] b;
        logic [SW-1:0] rad;
        logic [LW+1:0] rem;
        logic [LW-1:0] root;
    } r_t;

    typedef struct packed {
        geom_t         g;
        logic          hit;
        logic [TW-1:0] t;
        logic [LW-1:0] len;
    } g_t;

    typedef struct packed {
        vec32_t        s;
        logic          hit;
        logic [TW-1:0] t;
        logic [LW-1:0] len;
        vecw_t         prod;
        logic [2:0]    neg;
    } h_t;

    typedef struct packed {
        vec32_t              s;
        logic                hit;
        logic [TW-1:0]       t;
        logic [LW-1:0]       len;
        vecw_t               rem;
        logic [2:0]          neg;
        logic [2:0][QO-1:0]  q;
    } o_t;

    typedef struct packed {
        logic [LW+1:0] rem;
        logic [LW-1:0] root;
    } sq_res_t;

    typedef struct packed {
        logic [SW-1:0] rem;
        logic          q;
    } div_res_t;

    // one result bit of a floor square root
    function automatic sq_res_t sqrt_step(input logic [LW+1:0] rem,
                                          input logic [LW-1:0] root,
                                          input logic [1:0]    bits);
        logic [LW+1:0] cur;
        logic [LW+1:0] trial;
        sq_res_t       r;
        cur   = {rem[LW-1:0], bits};
        trial = {root, 2'b01};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {root[LW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {root[LW-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of a restoring divide, divisor shifted by sh
    function automatic div_res_t div_step(input logic [SW-1:0] rem,
                                          input logic [LW-1:0] dv,
                                          input int            sh);
        logic [SW:0] den;
        div_res_t    r;
        den = (SW+1)'(dv) << sh;
        if ({1'b0, rem} >= den)
        begin
            r.rem = rem - den[SW-1:0];
            r.q   = 1'b1;
        end
        else
        begin
            r.rem = rem;
            r.q   = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/segment_sphere_intersection.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while not stalled; the pipeline is 140
//   register stages, set by the bit-per-stage square roots (33 each) and
//   divides (34 and 32 stages).
// A stall freezes every stage; an empty first stage still takes a word.
// Reset (rst_n, async, active low) clears all valid bits and sets the radius
//   to 1.0; no clearing pass.
// ============================================================================
// segment_sphere_intersection - pipelined segment against sphere test
// Finds the first surface crossing of a segment with a sphere, fixed point.
// ============================================================================
module segment_sphere_intersection
    import ssi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic               sealed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [31:0]        distance,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z
);

    // ------------------------------------------------------------------
    // Control: one valid bit per stage, global advance on the output side.
    // Stage 0 may also load while it is empty during a stall.
    // ------------------------------------------------------------------
    logic [N_STAGES-1:0] vld_reg, vld_next;
    logic                adv, en0;
    logic [30:0]         radius_reg;

    assign adv       = ~vld_reg[N_STAGES-1] | out_ready;
    assign en0       = adv | ~vld_reg[0];
    assign in_ready  = en0;
    assign out_valid = vld_reg[N_STAGES-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (en0)
            vld_next[0] = in_valid;
        if (adv)
            vld_next[N_STAGES-1:1] = vld_reg[N_STAGES-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_we)
                radius_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: D = end - start, S = start - center (33 bit, exact)
    // ------------------------------------------------------------------
    a_t a_reg, a_next;
    logic [2:0][31:0] st_w, en_w, ce_w;

    assign st_w = {start_z, start_y, start_x};
    assign en_w = {end_z, end_y, end_x};
    assign ce_w = {center_z, center_y, center_x};

    always_comb
    begin
        a_next        = '0;
        a_next.sealed = sealed;
        for (int i = 0; i < 3; i++)
        begin
            a_next.g.s[i] = st_w[i];
            a_next.g.d[i] = {en_w[i][31], en_w[i]} - {st_w[i][31], st_w[i]};
            a_next.rel[i] = {st_w[i][31], st_w[i]} - {ce_w[i][31], ce_w[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
            a_reg <= a_next;
    end

    // ------------------------------------------------------------------
    // Stage B: nine 33x33 products plus r*r
    // ------------------------------------------------------------------
    b_t b_reg, b_next;
    logic signed [SW-1:0] p_dd [3];
    logic signed [SW-1:0] p_rd [3];
    logic signed [SW-1:0] p_rr [3];

    always_comb
    begin
        b_next        = '0;
        b_next.g      = a_reg.g;
        b_next.sealed = a_reg.sealed;
        b_next.rsq    = 62'(radius_reg) * 62'(radius_reg);
        for (int i = 0; i < 3; i++)
        begin
            p_dd[i] = $signed(a_reg.g.d[i]) * $signed(a_reg.g.d[i]);
            p_rd[i] = $signed(a_reg.rel[i]) * $signed(a_reg.g.d[i]);
            p_rr[i] = $signed(a_reg.rel[i]) * $signed(a_reg.rel[i]);
            b_next.dd[i] = p_dd[i];
            b_next.rd[i] = p_rd[i];
            b_next.rr[i] = p_rr[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: |D|^2, S.D, c = |S|^2 - r^2
    // ------------------------------------------------------------------
    c_t c_reg, c_next;
    logic signed [SW:0] c_ss;

    always_comb
    begin
        c_next        = '0;
        c_next.g      = b_reg.g;
        c_next.sealed = b_reg.sealed;
        c_next.len2   = b_reg.dd[0] + b_reg.dd[1] + b_reg.dd[2];
        c_next.dot    = $signed(b_reg.rd[0]) + $signed(b_reg.rd[1])
                      + $signed(b_reg.rd[2]);
        c_ss          = $signed(b_reg.rr[0]) + $signed(b_reg.rr[1])
                      + $signed(b_reg.rr[2]);
        c_next.c      = c_ss - $signed({5'b0, b_reg.rsq});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // L stages: length = floor(sqrt(|D|^2)), one root bit per stage
    // ------------------------------------------------------------------
    l_t l_reg [LW];
    l_t l_next [LW];

    for (genvar k = 0; k < LW; k++)
    begin : g_len
        l_t      src;
        sq_res_t st;
        if (k == 0)
        begin : g_src
            always_comb
            begin
                src        = '0;
                src.g      = c_reg.g;
                src.sealed = c_reg.sealed;
                src.dot    = c_reg.dot;
                src.c      = c_reg.c;
                src.rad    = c_reg.len2;
            end
        end
        else
        begin : g_src
            assign src = l_reg[k-1];
        end
        always_comb
        begin
            st             = sqrt_step(src.rem, src.root, src.rad[SW-1:SW-2]);
            l_next[k]      = src;
            l_next[k].rad  = src.rad << 2;
            l_next[k].rem  = st.rem;
            l_next[k].root = st.root;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            l_reg <= l_next;
    end

    // ------------------------------------------------------------------
    // D stages: b = S.D / length, toward zero; miss for unsealed or
    // degenerate segments is fixed here
    // ------------------------------------------------------------------
    d_t d_reg [QB];
    d_t d_next [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_bdiv
        d_t          src;
        div_res_t    dr;
        if (k == 0)
        begin : g_src
            logic [SW:0] dmag;
            always_comb
            begin
                dmag     = l_reg[LW-1].dot[SW] ? -l_reg[LW-1].dot : l_reg[LW-1].dot;
                src      = '0;
                src.g    = l_reg[LW-1].g;
                src.miss = ~l_reg[LW-1].sealed | (l_reg[LW-1].root <= DEGEN_LSB);
                src.c    = l_reg[LW-1].c;
                src.len  = l_reg[LW-1].root;
                src.neg  = l_reg[LW-1].dot[SW];
                src.rem  = dmag[SW-1:0];
            end
        end
        else
        begin : g_src
            assign src  = d_reg[k-1];
        end
        always_comb
        begin
            dr          = div_step(src.rem, src.len, QB - 1 - k);
            d_next[k]     = src;
            d_next[k].rem = dr.rem;
            d_next[k].q   = {src.q[QB-2:0], dr.q};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_reg <= d_next;
    end

    // ------------------------------------------------------------------
    // Stage E: signed b and b^2; stage F: discriminant b^2 - c
    // ------------------------------------------------------------------
    e_t e_reg, e_next;
    r_t f_reg, f_next;
    logic signed [SW+2:0] disc;

    always_comb
    begin
        e_next      = '0;
        e_next.g    = d_reg[QB-1].g;
        e_next.miss = d_reg[QB-1].miss;
        e_next.c    = d_reg[QB-1].c;
        e_next.len  = d_reg[QB-1].len;
        e_next.b    = d_reg[QB-1].neg ? -{1'b0, d_reg[QB-1].q} : {1'b0, d_reg[QB-1].q};
        e_next.bb   = (2*QB)'(d_reg[QB-1].q) * (2*QB)'(d_reg[QB-1].q);
    end

    always_comb
    begin
        disc        = $signed({1'b0, e_reg.bb}) - $signed(e_reg.c);
        f_next      = '0;
        f_next.g    = e_reg.g;
        f_next.miss = e_reg.miss | disc[SW+2];
        f_next.len  = e_reg.len;
        f_next.b    = e_reg.b;
        f_next.rad  = disc[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
            f_reg <= f_next;
        end
    end

    // ------------------------------------------------------------------
    // R stages: root = floor(sqrt(disc))
    // ------------------------------------------------------------------
    r_t r_reg [LW];
    r_t r_next [LW];

    for (genvar k = 0; k < LW; k++)
    begin : g_root
        r_t      src;
        sq_res_t st;
        if (k == 0)
        begin : g_src
            assign src = f_reg;
        end
        else
        begin : g_src
            assign src = r_reg[k-1];
        end
        always_comb
        begin
            st             = sqrt_step(src.rem, src.root, src.rad[SW-1:SW-2]);
            r_next[k]      = src;
            r_next[k].rad  = src.rad << 2;
            r_next[k].rem  = st.rem;
            r_next[k].root = st.root;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            r_reg <= r_next;
    end

    // ------------------------------------------------------------------
    // Stage G: near root, far root when the start is inside; range check
    // Stage H: |D_i| * t for the hit point
    // ------------------------------------------------------------------
    g_t g_reg, g_next;
    h_t h_reg, h_next;
    logic signed [BW:0] g_b, g_rt, g_t1, g_tv;
    logic [CW-1:0]      dmag_h [3];

    always_comb
    begin
        g_b        = $signed(r_reg[LW-1].b);
        g_rt       = $signed({3'b0, r_reg[LW-1].root});
        g_t1       = -g_b - g_rt;
        g_tv       = g_t1[BW] ? (-g_b + g_rt) : g_t1;
        g_next     = '0;
        g_next.g   = r_reg[LW-1].g;
        g_next.len = r_reg[LW-1].len;
        g_next.t   = g_tv[TW-1:0];
        g_next.hit = ~(r_reg[LW-1].miss | g_tv[BW]
                       | (g_tv > $signed({3'b0, r_reg[LW-1].len})));
    end

    always_comb
    begin
        h_next     = '0;
        h_next.s   = g_reg.g.s;
        h_next.hit = g_reg.hit;
        h_next.t   = g_reg.t;
        h_next.len = g_reg.len;
        for (int i = 0; i < 3; i++)
        begin
            dmag_h[i]      = g_reg.g.d[i][CW-1] ? -g_reg.g.d[i] : g_reg.g.d[i];
            h_next.neg[i]  = g_reg.g.d[i][CW-1];
            h_next.prod[i] = SW'(dmag_h[i][31:0]) * SW'(g_reg.t);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg <= g_next;
            h_reg <= h_next;
        end
    end

    // ------------------------------------------------------------------
    // O stages: offset_i = D_i * t / length, three lanes side by side
    // ------------------------------------------------------------------
    o_t o_reg [QO];
    o_t o_next [QO];

    for (genvar k = 0; k < QO; k++)
    begin : g_odiv
        o_t       src;
        div_res_t dr [3];
        if (k == 0)
        begin : g_src
            always_comb
            begin
                src     = '0;
                src.s   = h_reg.s;
                src.hit = h_reg.hit;
                src.t   = h_reg.t;
                src.len = h_reg.len;
                src.rem = h_reg.prod;
                src.neg = h_reg.neg;
            end
        end
        else
        begin : g_src
            assign src = o_reg[k-1];
        end
        always_comb
        begin
            o_next[k] = src;
            for (int i = 0; i < 3; i++)
            begin
                dr[i]            = div_step(src.rem[i], src.len, QO - 1 - k);
                o_next[k].rem[i] = dr[i].rem;
                o_next[k].q[i]   = {src.q[i][QO-2:0], dr[i].q};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_reg <= o_next;
    end

    // ------------------------------------------------------------------
    // Output register: point = start + offset, saturated distance,
    // everything zero on a miss
    // ------------------------------------------------------------------
    logic              hit_reg, hit_next;
    logic [31:0]       dist_reg, dist_next;
    logic [2:0][31:0]  pt_reg, pt_next;
    logic [QO:0]       off [3];

    always_comb
    begin
        hit_next  = o_reg[QO-1].hit;
        dist_next = '0;
        pt_next   = '0;
        if (o_reg[QO-1].hit)
            dist_next = o_reg[QO-1].t[TW-1] ? 32'hFFFF_FFFF : o_reg[QO-1].t[31:0];
        for (int i = 0; i < 3; i++)
        begin
            off[i] = o_reg[QO-1].neg[i] ? -{1'b0, o_reg[QO-1].q[i]}
                                        : {1'b0, o_reg[QO-1].q[i]};
            if (o_reg[QO-1].hit)
                pt_next[i] = o_reg[QO-1].s[i] + off[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
            pt_reg   <= pt_next;
        end
    end

    assign hit      = hit_reg;
    assign distance = dist_reg;
    assign point_x  = $signed(pt_reg[0]);
    assign point_y  = $signed(pt_reg[1]);
    assign point_z  = $signed(pt_reg[2]);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[N_STAGES-1:1]))
        else $error("pipeline moved during a stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (distance == '0 && point_x == '0
                                 && point_y == '0 && point_z == '0))
        else $error("miss word carries nonzero fields");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word not captured");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule
